// ----- hdl/mpllm_pkg.sv -----
`timescale 1ns / 1ps
package mpllm_pkg;

  // Table geometry and line limit
  localparam int PATTERNS    = 4;
  localparam int PATTERN_MAX = 16;
  localparam int LINE_LIMIT  = 4096;
  // Window holds the candidate bytes plus the byte to the left of a match
  localparam int WINDOW      = PATTERN_MAX + 1;

  // Field widths
  localparam int OpW    = 2;
  localparam int SlotW  = 2;
  localparam int IdxW   = 4;
  localparam int LenW   = 5;
  localparam int PosW   = 13;
  localparam int StartW = 12;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  // Character constants
  localparam logic [7:0] CaseGap    = 8'd32;
  localparam logic [7:0] CharUnder  = 8'h5F;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;

  typedef enum logic [OpW-1:0] {
    OP_TEXT     = 2'd0,
    OP_EOL      = 2'd1,
    OP_PAT_BYTE = 2'd2,
    OP_PAT_LEN  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_FOLD_CASE     = 3'd0,
    REG_WORD_BOUND    = 3'd1,
    REG_WHOLE_LINE    = 3'd2,
    REG_INVERT_SELECT = 3'd3,
    REG_SEARCH_FROM   = 3'd4
  } reg_e;

  typedef logic [PATTERN_MAX-1:0][7:0]          pattern_row_t;
  typedef logic [PATTERNS-1:0][PATTERN_MAX-1:0][7:0] pattern_tab_t;
  typedef logic [PATTERNS-1:0][LenW-1:0]        len_arr_t;
  typedef logic [PATTERNS-1:0][StartW-1:0]      start_arr_t;
  typedef logic [WINDOW-1:0][7:0]               window_t;

  // Per-check controls shared by all slot comparators
  typedef struct packed {
    logic              fold_case;
    logic              word_bound;
    logic [StartW-1:0] search_from;
    logic              has_right;
    logic [7:0]        right_byte;
    logic [PosW-1:0]   line_pos;
  } match_ctrl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    if (c >= (CharLowerA - CaseGap) && c <= (CharLowerZ - CaseGap)) begin
      return c + CaseGap;
    end
    return c;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    logic [7:0] f;
    f = fold_byte(c);
    return (f >= CharLowerA && f <= CharLowerZ) ||
           (c >= CharZero && c <= CharNine) || (c == CharUnder);
  endfunction

  function automatic logic bytes_equal(input logic [7:0] a, input logic [7:0] b,
                                       input logic ic);
    return (a == b) || (ic && (fold_byte(a) == fold_byte(b)));
  endfunction

endpackage

// ----- hdl/mpllm_in_if.sv -----
`timescale 1ns / 1ps
interface mpllm_in_if;
  logic                          valid;
  logic                          ready;
  logic [mpllm_pkg::OpW-1:0]     op;
  logic [7:0]                    data_byte;
  logic [mpllm_pkg::SlotW-1:0]   pattern_slot;
  logic [mpllm_pkg::IdxW-1:0]    byte_index;
  logic [mpllm_pkg::LenW-1:0]    pattern_length;

  modport source (
    output valid, op, data_byte, pattern_slot, byte_index, pattern_length,
    input  ready
  );
  modport sink (
    input  valid, op, data_byte, pattern_slot, byte_index, pattern_length,
    output ready
  );
endinterface

// ----- hdl/mpllm_out_if.sv -----
`timescale 1ns / 1ps
interface mpllm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          line_selected;
  logic                          found;
  logic [mpllm_pkg::StartW-1:0]  match_start;
  logic [mpllm_pkg::LenW-1:0]    match_length;
  logic [mpllm_pkg::PosW-1:0]    line_length;
  logic                          truncated;

  modport source (
    output valid, line_selected, found, match_start, match_length, line_length,
           truncated,
    input  ready
  );
  modport sink (
    input  valid, line_selected, found, match_start, match_length, line_length,
           truncated,
    output ready
  );
endinterface

// ----- hdl/mpllm_pattern_store.sv -----
`timescale 1ns / 1ps
module mpllm_pattern_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         byte_we_i,
  input  logic                         len_we_i,
  input  logic [mpllm_pkg::SlotW-1:0]  slot_i,
  input  logic [mpllm_pkg::IdxW-1:0]   index_i,
  input  logic [7:0]                   byte_i,
  input  logic [mpllm_pkg::LenW-1:0]   length_i,
  output mpllm_pkg::pattern_tab_t      table_o,
  output mpllm_pkg::len_arr_t          lengths_o
);

  mpllm_pkg::pattern_tab_t table_q;
  mpllm_pkg::len_arr_t     lengths_q;
  logic [mpllm_pkg::LenW-1:0] len_clamped;

  // Lengths above the maximum clamp to the maximum
  assign len_clamped = (length_i > mpllm_pkg::LenW'(mpllm_pkg::PATTERN_MAX)) ?
                       mpllm_pkg::LenW'(mpllm_pkg::PATTERN_MAX) : length_i;

  // Pattern bytes: no reset, contents valid once written
  always_ff @(posedge clk_i) begin
    if (byte_we_i) begin
      table_q[slot_i][index_i] <= byte_i;
    end
  end

  // Pattern lengths: reset disables every slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lengths_q <= '0;
    end else if (len_we_i) begin
      lengths_q[slot_i] <= len_clamped;
    end
  end

  assign table_o   = table_q;
  assign lengths_o = lengths_q;

endmodule

// ----- hdl/mpllm_slot_match.sv -----
`timescale 1ns / 1ps
module mpllm_slot_match (
  input  mpllm_pkg::window_t            window_i,
  input  mpllm_pkg::pattern_row_t       pattern_i,
  input  logic [mpllm_pkg::LenW-1:0]    length_i,
  input  mpllm_pkg::match_ctrl_t        ctrl_i,
  output logic                          match_o,
  output logic [mpllm_pkg::StartW-1:0]  start_o
);

  logic [mpllm_pkg::PosW-1:0] start_full;
  logic                       bytes_ok;
  logic                       left_bad;
  logic                       right_bad;
  logic [mpllm_pkg::LenW-1:0] widx;

  // Window[0] holds the last byte of the candidate; pattern byte j sits at len-1-j
  always_comb begin
    start_full = ctrl_i.line_pos - mpllm_pkg::PosW'(length_i);
    bytes_ok   = 1'b1;
    widx       = '0;
    for (int j = 0; j < mpllm_pkg::PATTERN_MAX; j++) begin
      if (mpllm_pkg::LenW'(j) < length_i) begin
        widx = length_i - mpllm_pkg::LenW'(1) - mpllm_pkg::LenW'(j);
        if (!mpllm_pkg::bytes_equal(window_i[widx], pattern_i[j],
                                    ctrl_i.fold_case)) begin
          bytes_ok = 1'b0;
        end
      end
    end
    left_bad  = ctrl_i.word_bound && (start_full != '0) &&
                mpllm_pkg::is_word(window_i[length_i]);
    right_bad = ctrl_i.word_bound && ctrl_i.has_right &&
                mpllm_pkg::is_word(ctrl_i.right_byte);
    match_o   = (length_i != '0) &&
                (ctrl_i.line_pos >= mpllm_pkg::PosW'(length_i)) &&
                (start_full >= mpllm_pkg::PosW'(ctrl_i.search_from)) &&
                bytes_ok && !left_bad && !right_bad;
    start_o   = start_full[mpllm_pkg::StartW-1:0];
  end

endmodule

// ----- hdl/mpllm_pick.sv -----
`timescale 1ns / 1ps
module mpllm_pick (
  input  logic [mpllm_pkg::PATTERNS-1:0] hit_i,
  input  mpllm_pkg::start_arr_t          start_i,
  input  mpllm_pkg::len_arr_t            length_i,
  input  logic                           whole_line_i,
  input  logic [mpllm_pkg::StartW-1:0]   search_from_i,
  input  logic [mpllm_pkg::PosW-1:0]     line_pos_i,
  output logic                           found_o,
  output logic [mpllm_pkg::StartW-1:0]   start_o,
  output logic [mpllm_pkg::LenW-1:0]     length_o
);

  logic usable;

  // Leftmost start wins, then longest, then lowest slot
  always_comb begin
    found_o  = 1'b0;
    start_o  = '0;
    length_o = '0;
    usable   = 1'b0;
    if (!(whole_line_i && (search_from_i != '0))) begin
      for (int s = 0; s < mpllm_pkg::PATTERNS; s++) begin
        usable = hit_i[s] && (length_i[s] != '0) &&
                 !(whole_line_i && ((start_i[s] != '0) ||
                   (mpllm_pkg::PosW'(length_i[s]) != line_pos_i)));
        if (usable && (!found_o || (start_i[s] < start_o) ||
            ((start_i[s] == start_o) && (length_i[s] > length_o)))) begin
          found_o  = 1'b1;
          start_o  = start_i[s];
          length_o = length_i[s];
        end
      end
    end
  end

endmodule

// ----- hdl/multi_pattern_literal_line_matcher_top.sv -----
`timescale 1ns / 1ps
// Channel   | Dir | Modport | Payload
// ----------+-----+---------+--------------------------------------------------
// item_i    | in  | sink    | op, data_byte, pattern_slot, byte_index,
//           |     |         | pattern_length
// result_o  | out | source  | line_selected, found, match_start, match_length,
//           |     |         | line_length, truncated
// APB       | in  | slave   | psel/penable/pwrite/paddr/pwdata, prdata, pready
//
// One item per cycle while item_i is not stalled: an accepted item is held in the input
// register, and the window compare against all slots and the state update happen as it
// leaves that register. An end-of-line result goes from the input register into the
// result register and is valid on result_o from there until result_o takes it.
// Reset clears the line state, the slot lengths and the registers; pattern bytes
// are not reset. item_i stalls only while an end-of-line item waits on a full
// result register that result_o does not drain.
module multi_pattern_literal_line_matcher_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mpllm_in_if.sink                     item_i,
  mpllm_out_if.source                  result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mpllm_pkg::AddrW-1:0]  paddr,
  input  logic [mpllm_pkg::DataW-1:0]  pwdata,
  output logic [mpllm_pkg::DataW-1:0]  prdata,
  output logic                         pready
);

  // Configuration registers
  logic                         fold_case_q;
  logic                         word_bound_q;
  logic                         whole_line_q;
  logic                         invert_select_q;
  logic [mpllm_pkg::StartW-1:0] search_from_q;
  mpllm_pkg::reg_e              reg_idx;

  // Input register
  logic                         s1_valid_q;
  mpllm_pkg::op_e               s1_op_q;
  logic [7:0]                   s1_byte_q;
  logic [mpllm_pkg::SlotW-1:0]  s1_slot_q;
  logic [mpllm_pkg::IdxW-1:0]   s1_index_q;
  logic [mpllm_pkg::LenW-1:0]   s1_len_q;
  logic                         s1_go;
  logic                         s1_is_text;
  logic                         s1_is_eol;
  logic                         text_take;
  logic                         eol_take;

  // Line state
  mpllm_pkg::window_t           window_q;
  mpllm_pkg::window_t           window_d;
  logic [mpllm_pkg::PosW-1:0]   line_pos_q;
  logic [mpllm_pkg::PosW-1:0]   line_pos_d;
  logic                         overflow_q;
  logic                         overflow_d;
  logic [mpllm_pkg::PATTERNS-1:0] slot_hit_q;
  logic [mpllm_pkg::PATTERNS-1:0] slot_hit_d;
  mpllm_pkg::start_arr_t        slot_start_q;
  mpllm_pkg::start_arr_t        slot_start_d;

  // Compare results
  mpllm_pkg::pattern_tab_t      pat_table;
  mpllm_pkg::len_arr_t          pat_lengths;
  mpllm_pkg::match_ctrl_t       mctrl;
  logic [mpllm_pkg::PATTERNS-1:0] slot_match;
  mpllm_pkg::start_arr_t        match_start;
  logic [mpllm_pkg::PATTERNS-1:0] new_hit;
  logic [mpllm_pkg::PATTERNS-1:0] eff_hit;
  mpllm_pkg::start_arr_t        eff_start;
  logic                         pick_found;
  logic [mpllm_pkg::StartW-1:0] pick_start;
  logic [mpllm_pkg::LenW-1:0]   pick_len;

  // Result register
  logic                         res_valid_q;
  logic                         res_found_q;
  logic                         res_sel_q;
  logic [mpllm_pkg::StartW-1:0] res_start_q;
  logic [mpllm_pkg::LenW-1:0]   res_len_q;
  logic [mpllm_pkg::PosW-1:0]   res_line_len_q;
  logic                         res_trunc_q;

  // ---------------------------------------------------------------------------
  // APB register port
  assign pready  = 1'b1;
  assign reg_idx = mpllm_pkg::reg_e'(paddr[mpllm_pkg::AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_case_q     <= 1'b0;
      word_bound_q    <= 1'b0;
      whole_line_q    <= 1'b0;
      invert_select_q <= 1'b0;
      search_from_q   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        mpllm_pkg::REG_FOLD_CASE:     fold_case_q     <= pwdata[0];
        mpllm_pkg::REG_WORD_BOUND:    word_bound_q    <= pwdata[0];
        mpllm_pkg::REG_WHOLE_LINE:    whole_line_q    <= pwdata[0];
        mpllm_pkg::REG_INVERT_SELECT: invert_select_q <= pwdata[0];
        mpllm_pkg::REG_SEARCH_FROM:   search_from_q   <= pwdata[mpllm_pkg::StartW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      mpllm_pkg::REG_FOLD_CASE:     prdata[0] = fold_case_q;
      mpllm_pkg::REG_WORD_BOUND:    prdata[0] = word_bound_q;
      mpllm_pkg::REG_WHOLE_LINE:    prdata[0] = whole_line_q;
      mpllm_pkg::REG_INVERT_SELECT: prdata[0] = invert_select_q;
      mpllm_pkg::REG_SEARCH_FROM:   prdata[mpllm_pkg::StartW-1:0] = search_from_q;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register and flow control
  assign s1_is_text = (s1_op_q == mpllm_pkg::OP_TEXT);
  assign s1_is_eol  = (s1_op_q == mpllm_pkg::OP_EOL);
  // Only an end-of-line item needs room in the result register
  assign s1_go      = s1_valid_q && (!s1_is_eol || !res_valid_q || result_o.ready);
  assign item_i.ready = !s1_valid_q || s1_go;
  assign text_take  = s1_go && s1_is_text &&
                      (line_pos_q < mpllm_pkg::PosW'(mpllm_pkg::LINE_LIMIT));
  assign eol_take   = s1_go && s1_is_eol;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      s1_op_q    <= mpllm_pkg::op_e'(item_i.op);
      s1_byte_q  <= item_i.data_byte;
      s1_slot_q  <= item_i.pattern_slot;
      s1_index_q <= item_i.byte_index;
      s1_len_q   <= item_i.pattern_length;
    end
  end

  // ---------------------------------------------------------------------------
  // Pattern table
  mpllm_pattern_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_we_i (s1_go && (s1_op_q == mpllm_pkg::OP_PAT_BYTE)),
    .len_we_i  (s1_go && (s1_op_q == mpllm_pkg::OP_PAT_LEN)),
    .slot_i    (s1_slot_q),
    .index_i   (s1_index_q),
    .byte_i    (s1_byte_q),
    .length_i  (s1_len_q),
    .table_o   (pat_table),
    .lengths_o (pat_lengths)
  );

  // ---------------------------------------------------------------------------
  // Slot compares: candidate ends at window[0]; a text byte is its right neighbor
  assign mctrl.fold_case   = fold_case_q;
  assign mctrl.word_bound  = word_bound_q;
  assign mctrl.search_from = search_from_q;
  assign mctrl.has_right   = s1_is_text;
  assign mctrl.right_byte  = s1_byte_q;
  assign mctrl.line_pos    = line_pos_q;

  for (genvar s = 0; s < mpllm_pkg::PATTERNS; s++) begin : g_slot
    mpllm_slot_match u_match (
      .window_i  (window_q),
      .pattern_i (pat_table[s]),
      .length_i  (pat_lengths[s]),
      .ctrl_i    (mctrl),
      .match_o   (slot_match[s]),
      .start_o   (match_start[s])
    );
    assign new_hit[s]   = slot_match[s] && !slot_hit_q[s];
    assign eff_hit[s]   = slot_hit_q[s] || slot_match[s];
    assign eff_start[s] = slot_hit_q[s] ? slot_start_q[s] : match_start[s];
  end

  // ---------------------------------------------------------------------------
  // Best match over slots, including hits that end at the line end
  mpllm_pick u_pick (
    .hit_i         (eff_hit),
    .start_i       (eff_start),
    .length_i      (pat_lengths),
    .whole_line_i  (whole_line_q),
    .search_from_i (search_from_q),
    .line_pos_i    (line_pos_q),
    .found_o       (pick_found),
    .start_o       (pick_start),
    .length_o      (pick_len)
  );

  // ---------------------------------------------------------------------------
  // Line state update
  always_comb begin
    window_d     = window_q;
    line_pos_d   = line_pos_q;
    overflow_d   = overflow_q;
    slot_hit_d   = slot_hit_q;
    slot_start_d = slot_start_q;
    if (eol_take) begin
      window_d     = '0;
      line_pos_d   = '0;
      overflow_d   = 1'b0;
      slot_hit_d   = '0;
      slot_start_d = '0;
    end else if (text_take) begin
      window_d   = {window_q[mpllm_pkg::WINDOW-2:0], s1_byte_q};
      line_pos_d = line_pos_q + mpllm_pkg::PosW'(1);
      for (int s = 0; s < mpllm_pkg::PATTERNS; s++) begin
        if (new_hit[s]) begin
          slot_hit_d[s]   = 1'b1;
          slot_start_d[s] = match_start[s];
        end
      end
    end else if (s1_go && s1_is_text) begin
      overflow_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= '0;
      line_pos_q   <= '0;
      overflow_q   <= 1'b0;
      slot_hit_q   <= '0;
      slot_start_q <= '0;
    end else begin
      window_q     <= window_d;
      line_pos_q   <= line_pos_d;
      overflow_q   <= overflow_d;
      slot_hit_q   <= slot_hit_d;
      slot_start_q <= slot_start_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (eol_take) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eol_take) begin
      res_found_q    <= pick_found;
      res_sel_q      <= pick_found ^ invert_select_q;
      res_start_q    <= pick_start;
      res_len_q      <= pick_len;
      res_line_len_q <= line_pos_q;
      res_trunc_q    <= overflow_q;
    end
  end

  assign result_o.valid         = res_valid_q;
  assign result_o.line_selected = res_sel_q;
  assign result_o.found         = res_found_q;
  assign result_o.match_start   = res_start_q;
  assign result_o.match_length  = res_len_q;
  assign result_o.line_length   = res_line_len_q;
  assign result_o.truncated     = res_trunc_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_pos_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_pos_q <= mpllm_pkg::PosW'(mpllm_pkg::LINE_LIMIT))
    else $error("line position past limit");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |-> (line_pos_q == mpllm_pkg::PosW'(mpllm_pkg::LINE_LIMIT)))
    else $error("overflow flagged before line filled");

  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eol_take |=> (line_pos_q == '0) && !overflow_q && (slot_hit_q == '0))
    else $error("line state not cleared after end of line");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_i.ready |-> (s1_valid_q && s1_is_eol && res_valid_q && !result_o.ready))
    else $error("input stalled without a blocked result");

  a_result_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eol_take |=> res_valid_q)
    else $error("end of line gave no result");

endmodule
